/* design/hrf_pkg.sv */
// ----------------------------------------------------------------------------
// hrf_pkg
// Shared types and constants of the HEVC RTP fragmenter.
// ----------------------------------------------------------------------------
package hrf_pkg;

   localparam int LenBits        = 24;
   localparam int MaxPayloadBits = 12;
   localparam int StampBits      = 32;

   localparam logic [MaxPayloadBits-1:0] MaxPayloadReset = MaxPayloadBits'(1420);
   localparam logic [MaxPayloadBits-1:0] MaxPayloadFloor = MaxPayloadBits'(4);
   localparam logic [MaxPayloadBits-1:0] FuHeaderBytes   = MaxPayloadBits'(3);

   localparam logic [7:0] IndicatorMask = 8'h81;
   localparam logic [5:0] FuNalType     = 6'd49;

   localparam int QueueDepth     = 4;
   localparam int QueuePtrBits   = $clog2(QueueDepth);
   localparam int QueueCountBits = $clog2(QueueDepth + 1);

   // output beat of a queued job
   typedef enum logic [1:0] {
      BeatIndicator = 2'd0,
      BeatLayer     = 2'd1,
      BeatFuHeader  = 2'd2,
      BeatData      = 2'd3
   } beat_type;

   typedef struct packed {
      logic                 with_header;
      logic [7:0]           data_byte;
      logic [7:0]           indicator;
      logic [7:0]           layer;
      logic [7:0]           fu_header;
      logic                 pkt_start;
      logic                 pkt_end;
      logic                 marker;
      logic [StampBits-1:0] stamp;
      logic [7:0]           kind;
      logic [7:0]           channel;
   } hrf_job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } hrf_qstat_type;

endpackage

/* design/hrf_if.sv */
// ----------------------------------------------------------------------------
// hrf interfaces
// Valid/ready channels of the HEVC RTP fragmenter: bytes in, payload out, csr.
// ----------------------------------------------------------------------------
interface hrf_req_if import hrf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [7:0]           data_byte;
   logic [LenBits-1:0]   unit_length;
   logic                 marker_in;
   logic [StampBits-1:0] stamp_in;
   logic [StampBits-1:0] now_ticks;
   logic [7:0]           frame_kind;
   logic [7:0]           channel;

   modport source (output valid, data_byte, unit_length, marker_in, stamp_in,
                   now_ticks, frame_kind, channel, input ready);
   modport sink   (input valid, data_byte, unit_length, marker_in, stamp_in,
                   now_ticks, frame_kind, channel, output ready);
endinterface

interface hrf_rsp_if import hrf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [7:0]           out_byte;
   logic                 packet_start;
   logic                 packet_end;
   logic                 marker_out;
   logic [StampBits-1:0] stamp_out;
   logic [7:0]           kind_out;
   logic [7:0]           channel_out;
   logic                 run_last;

   modport source (output valid, out_byte, packet_start, packet_end, marker_out,
                   stamp_out, kind_out, channel_out, run_last, input ready);
   modport sink   (input valid, out_byte, packet_start, packet_end, marker_out,
                   stamp_out, kind_out, channel_out, run_last, output ready);
endinterface

interface hrf_csr_if import hrf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [MaxPayloadBits-1:0] max_payload;

   modport source (output valid, max_payload, input ready);
   modport sink   (input valid, max_payload, output ready);
endinterface

/* design/hrf_front.sv */
// ----------------------------------------------------------------------------
// hrf_front
// Accepts NAL bytes, tracks unit and packet position, and queues one job per
// byte that produces output.
// ----------------------------------------------------------------------------
module hrf_front import hrf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   hrf_req_if.sink                   req_chan,
   input  logic [MaxPayloadBits-1:0] max_payload,
   input  hrf_qstat_type             q_status,
   output logic                      push,
   output hrf_job_type               push_job
);

   logic [LenBits-1:0]        byte_index_ff, byte_index_in;
   logic [LenBits-1:0]        pkt_base_ff, pkt_base_in;
   logic [MaxPayloadBits-1:0] fill_ff, fill_in;
   logic                      frag_ff, frag_in;
   logic                      first_frag_ff, first_frag_in;
   logic [7:0]                indicator_ff, indicator_in;
   logic [7:0]                layer_ff, layer_in;
   logic [5:0]                unit_type_ff, unit_type_in;
   logic [StampBits-1:0]      stamp_ff, stamp_in;

   logic                      accept;
   logic [LenBits-1:0]        len;
   logic                      first_byte;
   logic [MaxPayloadBits-1:0] mp;
   logic [MaxPayloadBits-1:0] cap;
   logic                      last_byte;
   logic                      frag_now;
   logic                      first_frag_now;
   logic [StampBits-1:0]      stamp_now;
   logic                      data_branch;
   logic                      final_pkt;
   logic                      pkt_done;
   logic                      need_header;

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      len = (req_chan.unit_length == '0) ? LenBits'(1) : req_chan.unit_length;
      first_byte = (byte_index_ff == '0);
      mp  = (max_payload < MaxPayloadFloor) ? MaxPayloadFloor : max_payload;
      cap = mp - FuHeaderBytes;
      last_byte = ({1'b0, byte_index_ff} + (LenBits+1)'(1)) >= {1'b0, len};
      frag_now  = first_byte ? (len > LenBits'(mp)) : frag_ff;
      first_frag_now = first_byte ? 1'b1 : first_frag_ff;
      if (first_byte) begin
         stamp_now = (req_chan.stamp_in != '0) ? req_chan.stamp_in : req_chan.now_ticks;
      end else begin
         stamp_now = stamp_ff;
      end
      data_branch = frag_now && (byte_index_ff > LenBits'(1));
      // last packet once the rest of the unit fits from the packet base
      final_pkt   = {1'b0, len} <= ({1'b0, pkt_base_ff} + (LenBits+1)'(cap));
      pkt_done    = (({1'b0, fill_ff} + (MaxPayloadBits+1)'(1)) >= {1'b0, cap}) || last_byte;
      need_header = data_branch && (fill_ff == '0);

      push = accept && (!frag_now || data_branch);
      push_job.with_header = need_header;
      push_job.data_byte   = req_chan.data_byte;
      push_job.indicator   = indicator_ff;
      push_job.layer       = layer_ff;
      push_job.fu_header   = {first_frag_now, final_pkt, unit_type_ff};
      push_job.pkt_start   = !frag_now && first_byte;
      push_job.pkt_end     = frag_now ? pkt_done : last_byte;
      push_job.marker      = frag_now ? final_pkt : req_chan.marker_in;
      push_job.stamp       = stamp_now;
      push_job.kind        = req_chan.frame_kind;
      push_job.channel     = req_chan.channel;
   end

   always_comb begin
      byte_index_in = byte_index_ff;
      pkt_base_in   = pkt_base_ff;
      fill_in       = fill_ff;
      frag_in       = frag_ff;
      first_frag_in = first_frag_ff;
      indicator_in  = indicator_ff;
      layer_in      = layer_ff;
      unit_type_in  = unit_type_ff;
      stamp_in      = stamp_ff;
      if (accept) begin
         frag_in       = frag_now;
         stamp_in      = stamp_now;
         first_frag_in = need_header ? 1'b0 : first_frag_now;
         if (frag_now && first_byte) begin
            indicator_in = (req_chan.data_byte & IndicatorMask) | {1'b0, FuNalType, 1'b0};
            unit_type_in = req_chan.data_byte[6:1];
         end
         if (frag_now && (byte_index_ff == LenBits'(1))) begin
            layer_in = req_chan.data_byte;
         end
         if (data_branch) begin
            fill_in = pkt_done ? '0 : fill_ff + MaxPayloadBits'(1);
         end
         if (last_byte) begin
            byte_index_in = '0;
            pkt_base_in   = '0;
            fill_in       = '0;
         end else begin
            byte_index_in = byte_index_ff + LenBits'(1);
            pkt_base_in   = (data_branch && !pkt_done) ? pkt_base_ff
                                                       : byte_index_ff + LenBits'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         pkt_base_ff   <= '0;
         fill_ff       <= '0;
         frag_ff       <= 1'b0;
         first_frag_ff <= 1'b1;
      end else begin
         byte_index_ff <= byte_index_in;
         pkt_base_ff   <= pkt_base_in;
         fill_ff       <= fill_in;
         frag_ff       <= frag_in;
         first_frag_ff <= first_frag_in;
      end
   end

   always_ff @(posedge clock) begin
      indicator_ff <= indicator_in;
      layer_ff     <= layer_in;
      unit_type_ff <= unit_type_in;
      stamp_ff     <= stamp_in;
   end

   // the packet base trails the byte position by the packet fill
   a_base_behind: assert property (@(posedge clock) disable iff (reset)
      pkt_base_ff <= byte_index_ff)
      else $error("packet base ahead of byte index");

endmodule

/* design/hrf_queue.sv */
// ----------------------------------------------------------------------------
// hrf_queue
// Small job queue between the classifying front and the output back end.
// ----------------------------------------------------------------------------
module hrf_queue import hrf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  hrf_job_type   push_job,
   input  logic          pop,
   output hrf_job_type   head,
   output hrf_qstat_type status
);

   hrf_job_type               entries_ff [QueueDepth];
   logic [QueuePtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCountBits-1:0] count_ff, count_in;

   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == QueueCountBits'(QueueDepth));
      head         = entries_ff[rd_ptr_ff];
      wr_ptr_in    = push ? wr_ptr_ff + QueuePtrBits'(1) : wr_ptr_ff;
      rd_ptr_in    = pop  ? rd_ptr_ff + QueuePtrBits'(1) : rd_ptr_ff;
      count_in     = count_ff + QueueCountBits'(push) - QueueCountBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!status.full || pop))
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("job queue underflow");

endmodule

/* design/hrf_back.sv */
// ----------------------------------------------------------------------------
// hrf_back
// Expands queued jobs into payload bytes, FU header first where needed, into
// a registered output stage.
// ----------------------------------------------------------------------------
module hrf_back import hrf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  hrf_job_type   head,
   input  hrf_qstat_type q_status,
   output logic          pop,
   hrf_rsp_if.source     rsp_chan
);

   beat_type             beat_ff, beat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 start_ff, start_in;
   logic                 end_ff, end_in;
   logic                 marker_ff;
   logic [StampBits-1:0] stamp_ff;
   logic [7:0]           kind_ff;
   logic [7:0]           channel_ff;
   logic                 run_last_ff, run_last_in;

   logic                 load;
   logic                 last_beat;
   beat_type             cur_beat;

   always_comb begin
      load      = !q_status.empty && (!rsp_valid_ff || rsp_chan.ready);
      cur_beat  = head.with_header ? beat_ff : BeatData;
      last_beat = (cur_beat == BeatData);
      pop       = load && last_beat;
      if (!load) begin
         beat_in = beat_ff;
      end else if (last_beat) begin
         beat_in = BeatIndicator;
      end else begin
         beat_in = beat_type'(beat_ff + 2'd1);
      end

      start_in = 1'b0;
      end_in   = 1'b0;
      unique case (cur_beat)
         BeatIndicator: begin
            byte_in  = head.indicator;
            start_in = 1'b1;
         end
         BeatLayer:    byte_in = head.layer;
         BeatFuHeader: byte_in = head.fu_header;
         BeatData: begin
            byte_in  = head.data_byte;
            start_in = head.pkt_start;
            end_in   = head.pkt_end;
         end
         default:      byte_in = head.data_byte;
      endcase
      run_last_in = last_beat;

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= BeatIndicator;
         rsp_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff     <= byte_in;
         start_ff    <= start_in;
         end_ff      <= end_in;
         marker_ff   <= head.marker;
         stamp_ff    <= head.stamp;
         kind_ff     <= head.kind;
         channel_ff  <= head.channel;
         run_last_ff <= run_last_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_byte     = byte_ff;
   assign rsp_chan.packet_start = start_ff;
   assign rsp_chan.packet_end   = end_ff;
   assign rsp_chan.marker_out   = marker_ff;
   assign rsp_chan.stamp_out    = stamp_ff;
   assign rsp_chan.kind_out     = kind_ff;
   assign rsp_chan.channel_out  = channel_ff;
   assign rsp_chan.run_last     = run_last_ff;

   // mid-header position only while a header job sits at the head
   a_beat_on_header: assert property (@(posedge clock) disable iff (reset)
      (beat_ff != BeatIndicator) |-> (!q_status.empty && head.with_header))
      else $error("beat counter away from start without a header job");

endmodule

/* design/hevc_rtp_fragmenter_core.sv */
// ----------------------------------------------------------------------------
// hevc_rtp_fragmenter_core
// H.265 NAL unit to RTP payload bytes, single packet or type-49 FU packets.
// ----------------------------------------------------------------------------
//  channel    direction  carries
//  req_chan   in         one NAL byte with unit length, marker, stamps, ids
//  rsp_chan   out        one payload byte with packet flags, marker, stamp
//  csr_chan   in         max_payload write, always ready
//
//  a byte is taken every cycle while the 4-entry job queue has room
//  its first transfer passes through the job queue and then the registered output stage
//  4 transfers on the first data byte of a FU packet, none on FU unit headers, else 1
//  sustained rate is set by the output side: one payload byte per cycle while rsp_chan is ready
//  synchronous reset, no clearing pass; max_payload resets to 1420
//  either side may stall without stalling the other until the queue fills
// ----------------------------------------------------------------------------
module hevc_rtp_fragmenter_core import hrf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hrf_req_if.sink    req_chan,
   hrf_rsp_if.source  rsp_chan,
   hrf_csr_if.sink    csr_chan
);

   logic [MaxPayloadBits-1:0] max_payload_ff, max_payload_in;
   logic                      push;
   logic                      pop;
   hrf_job_type               push_job;
   hrf_job_type               head;
   hrf_qstat_type             q_status;

   assign csr_chan.ready = 1'b1;
   assign max_payload_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.max_payload
                                                              : max_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MaxPayloadReset;
      end else begin
         max_payload_ff <= max_payload_in;
      end
   end

   hrf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .max_payload (max_payload_ff),
      .q_status    (q_status),
      .push        (push),
      .push_job    (push_job)
   );

   hrf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   hrf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

/* tb/hevc_rtp_fragmenter_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevc_rtp_fragmenter_core_tb
// Feeds NAL unit bytes through the fragmenter under random backpressure and
// compares every payload transfer against an in-bench packetizer model.
// ----------------------------------------------------------------------------
module hevc_rtp_fragmenter_core_tb import hrf_pkg::*; ();

   localparam int         CycleLimit  = 200000;
   localparam int         IdlePercent = 18;
   localparam int         SettleWait  = 12;
   localparam logic [7:0] FuStartFlag = 8'h80;
   localparam logic [7:0] FuEndFlag   = 8'h40;

   typedef struct packed {
      logic [7:0]           data_byte;
      logic [LenBits-1:0]   unit_length;
      logic                 marker_in;
      logic [StampBits-1:0] stamp_in;
      logic [StampBits-1:0] now_ticks;
      logic [7:0]           frame_kind;
      logic [7:0]           channel;
   } nal_byte_type;

   typedef struct packed {
      logic [7:0]           out_byte;
      logic                 packet_start;
      logic                 packet_end;
      logic                 marker_out;
      logic [StampBits-1:0] stamp_out;
      logic [7:0]           kind_out;
      logic [7:0]           channel_out;
      logic                 run_last;
   } payload_byte_type;

   logic clock;
   logic reset;

   hrf_req_if req_if ();
   hrf_rsp_if rsp_if ();
   hrf_csr_if csr_if ();

   hevc_rtp_fragmenter_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // packetizer model state
   logic [MaxPayloadBits-1:0] max_payload_cfg;
   logic [LenBits-1:0]        unit_pos;
   logic [MaxPayloadBits-1:0] fu_fill;
   logic                      fu_mode;
   logic [7:0]                fu_indicator;
   logic [7:0]                fu_layer;
   logic [5:0]                fu_type;
   logic                      fu_first;
   logic [StampBits-1:0]      unit_stamp;

   payload_byte_type expected_payload[$];

   int error_count;
   int results_seen;
   int cycle_count;
   bit steady;

   // random unit attributes, held for the whole unit
   logic [LenBits-1:0]   gen_len;
   logic                 gen_marker;
   logic [StampBits-1:0] gen_stamp;
   logic [7:0]           gen_kind;
   logic [7:0]           gen_chan;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("mismatch on result %0d, %s: got %0h, expected %0h",
               results_seen, what, got, want);
      error_count++;
   endtask

   task automatic check_field(input string what, input longint unsigned got,
                              input longint unsigned want);
      if (got != want)
         report_mismatch(what, got, want);
   endtask

   function automatic void push_payload(input logic [7:0] value, input logic first,
                                        input logic closing, input logic mark,
                                        input nal_byte_type b, input logic run_end);
      payload_byte_type r;
      r.out_byte     = value;
      r.packet_start = first;
      r.packet_end   = closing;
      r.marker_out   = mark;
      r.stamp_out    = unit_stamp;
      r.kind_out     = b.frame_kind;
      r.channel_out  = b.channel;
      r.run_last     = run_end;
      expected_payload.push_back(r);
   endfunction

   function automatic void predict_payload(input nal_byte_type b);
      longint unsigned limit, cap, len, idx, pstart, remain;
      logic            last_byte, final_pkt, pend;
      logic [7:0]      fu_hdr;
      limit = 64'((max_payload_cfg < MaxPayloadFloor) ? MaxPayloadFloor : max_payload_cfg);
      cap = limit - 64'(FuHeaderBytes);
      len = (b.unit_length == '0) ? 64'd1 : 64'(b.unit_length);
      idx = 64'(unit_pos);
      last_byte = (idx + 64'd1 >= len);

      if (idx == 0) begin
         fu_mode = (len > limit);
         unit_stamp = (b.stamp_in != '0) ? b.stamp_in : b.now_ticks;
         fu_first = 1'b1;
         fu_fill = '0;
      end

      if (!fu_mode) begin
         push_payload(b.data_byte, idx == 0, last_byte, b.marker_in, b, 1'b1);
      end else if (idx == 0) begin
         fu_indicator = (b.data_byte & IndicatorMask) | {1'b0, FuNalType, 1'b0};
         fu_type = b.data_byte[6:1];
      end else if (idx == 1) begin
         fu_layer = b.data_byte;
      end else begin
         // data bytes still to come from the start of this packet
         pstart = (idx >= 64'(fu_fill)) ? idx - 64'(fu_fill) : 64'd0;
         remain = (pstart < len) ? len - pstart : 64'd1;
         final_pkt = (remain <= cap);
         if (fu_fill == '0) begin
            fu_hdr = (fu_first ? FuStartFlag : 8'h00) | (final_pkt ? FuEndFlag : 8'h00)
                     | {2'b00, fu_type};
            push_payload(fu_indicator, 1'b1, 1'b0, final_pkt, b, 1'b0);
            push_payload(fu_layer, 1'b0, 1'b0, final_pkt, b, 1'b0);
            push_payload(fu_hdr, 1'b0, 1'b0, final_pkt, b, 1'b0);
            fu_first = 1'b0;
         end
         pend = (64'(fu_fill) + 64'd1 >= cap) || last_byte;
         push_payload(b.data_byte, 1'b0, pend, final_pkt, b, 1'b1);
         fu_fill = pend ? '0 : fu_fill + 1'b1;
      end

      if (last_byte) begin
         unit_pos = '0;
         fu_fill = '0;
      end else begin
         unit_pos = LenBits'(idx + 1);
      end
   endfunction

   // one process samples all three channels, so prediction precedes checking
   always @(posedge clock) begin
      nal_byte_type     seen;
      payload_byte_type got;
      payload_byte_type want;
      if (reset) begin
         max_payload_cfg = MaxPayloadReset;
         unit_pos = '0;
         fu_fill = '0;
         fu_mode = 1'b0;
         fu_indicator = '0;
         fu_layer = '0;
         fu_type = '0;
         fu_first = 1'b1;
         unit_stamp = '0;
         expected_payload.delete();
      end else begin
         if (csr_if.valid && csr_if.ready)
            max_payload_cfg = csr_if.max_payload;
         if (req_if.valid && req_if.ready) begin
            seen.data_byte   = req_if.data_byte;
            seen.unit_length = req_if.unit_length;
            seen.marker_in   = req_if.marker_in;
            seen.stamp_in    = req_if.stamp_in;
            seen.now_ticks   = req_if.now_ticks;
            seen.frame_kind  = req_if.frame_kind;
            seen.channel     = req_if.channel;
            predict_payload(seen);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.out_byte     = rsp_if.out_byte;
            got.packet_start = rsp_if.packet_start;
            got.packet_end   = rsp_if.packet_end;
            got.marker_out   = rsp_if.marker_out;
            got.stamp_out    = rsp_if.stamp_out;
            got.kind_out     = rsp_if.kind_out;
            got.channel_out  = rsp_if.channel_out;
            got.run_last     = rsp_if.run_last;
            if (expected_payload.size() == 0) begin
               report_mismatch("unexpected transfer", got.out_byte, 0);
            end else begin
               want = expected_payload.pop_front();
               check_field("out_byte", got.out_byte, want.out_byte);
               check_field("packet_start", got.packet_start, want.packet_start);
               check_field("packet_end", got.packet_end, want.packet_end);
               check_field("marker_out", got.marker_out, want.marker_out);
               check_field("stamp_out", got.stamp_out, want.stamp_out);
               check_field("kind_out", got.kind_out, want.kind_out);
               check_field("channel_out", got.channel_out, want.channel_out);
               check_field("run_last", got.run_last, want.run_last);
            end
            results_seen++;
         end
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(99) >= IdlePercent);
   end

   // entered and left at a falling edge
   task automatic send_nal_byte(input nal_byte_type b);
      while (!steady && $urandom_range(99) < IdlePercent) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.data_byte   <= b.data_byte;
      req_if.unit_length <= b.unit_length;
      req_if.marker_in   <= b.marker_in;
      req_if.stamp_in    <= b.stamp_in;
      req_if.now_ticks   <= b.now_ticks;
      req_if.frame_kind  <= b.frame_kind;
      req_if.channel     <= b.channel;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [7:0] data, input logic [LenBits-1:0] len,
                              input logic mark, input logic [StampBits-1:0] stamp,
                              input logic [StampBits-1:0] now,
                              input logic [7:0] kind, input logic [7:0] chan);
      nal_byte_type b;
      b.data_byte   = data;
      b.unit_length = len;
      b.marker_in   = mark;
      b.stamp_in    = stamp;
      b.now_ticks   = now;
      b.frame_kind  = kind;
      b.channel     = chan;
      send_nal_byte(b);
   endtask

   // header bytes of a fragmented unit give no transfer, so allow a settle time
   task automatic wait_until_idle();
      req_if.valid <= 1'b0;
      while (expected_payload.size() != 0)
         @(posedge clock);
      repeat (SettleWait) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_max_payload(input logic [MaxPayloadBits-1:0] value);
      wait_until_idle();
      csr_if.valid       <= 1'b1;
      csr_if.max_payload <= value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_random_bytes(input int count);
      nal_byte_type    b;
      longint unsigned limit, cap;
      for (int k = 0; k < count; k++) begin
         if (unit_pos == '0) begin
            limit = 64'((max_payload_cfg < MaxPayloadFloor) ? MaxPayloadFloor
                                                            : max_payload_cfg);
            cap = limit - 64'(FuHeaderBytes);
            if (limit <= 64'd32 && $urandom_range(99) < 65)
               gen_len = LenBits'($urandom_range(32'(limit + 2 * cap + 2), 32'(limit + 1)));
            else
               gen_len = LenBits'($urandom_range(1, (limit < 12) ? 32'(limit) : 12));
            gen_marker = 1'($urandom_range(1));
            gen_stamp  = ($urandom_range(99) < 25) ? '0 : $urandom();
            gen_kind   = 8'($urandom_range(255));
            gen_chan   = 8'($urandom_range(255));
         end
         b.data_byte   = 8'($urandom_range(255));
         b.unit_length = gen_len;
         // occasional length that cuts the unit short
         if (unit_pos != '0 && $urandom_range(99) < 5)
            b.unit_length = LenBits'($urandom_range(32'(unit_pos) + 1, 0));
         b.marker_in  = gen_marker;
         b.stamp_in   = gen_stamp;
         b.now_ticks  = $urandom();
         b.frame_kind = gen_kind;
         b.channel    = gen_chan;
         send_nal_byte(b);
      end
   endtask

   task automatic test_single_packet();
      send_fields(8'hFF, 24'd1, 1'b1, 32'h0, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
      send_fields(8'h00, 24'd2, 1'b0, 32'hFFFF_FFFF, 32'h0, 8'h00, 8'h00);
      send_fields(8'h5A, 24'd2, 1'b0, 32'hFFFF_FFFF, 32'h0, 8'h00, 8'h00);
      // zero length behaves as a one-byte unit
      send_fields(8'hA5, 24'd0, 1'b1, 32'h1234_5678, 32'h0, 8'h3C, 8'hC3);
   endtask

   task automatic test_fu_split();
      write_max_payload(12'd5);
      send_fields(8'hFF, 24'd7, 1'b0, 32'h0, 32'h0BAD_F00D, 8'h11, 8'h22);
      send_fields(8'h01, 24'd7, 1'b0, 32'h0, 32'h0BAD_F00E, 8'h11, 8'h22);
      for (int k = 0; k < 5; k++)
         send_fields(8'(k * 37), 24'd7, 1'b0, 32'h0, 32'h0, 8'h11, 8'h22);
      // fragmented unit cut off on its second byte
      send_fields(8'h00, 24'd6, 1'b1, 32'h0000_0001, 32'h0, 8'h44, 8'h55);
      send_fields(8'h80, 24'd2, 1'b1, 32'h0000_0001, 32'h0, 8'h44, 8'h55);
   endtask

   task automatic test_limit_floor();
      write_max_payload(12'd0);
      for (int k = 0; k < 5; k++)
         send_fields(8'(8'h7E ^ k), 24'd5, 1'b0, 32'h8000_0000, 32'h0, 8'h01, 8'h02);
   endtask

   task automatic test_limit_change_in_unit();
      write_max_payload(12'd4095);
      for (int k = 0; k < 4; k++)
         send_fields(8'(k + 8'h40), 24'hFF_FFFF, 1'b0, 32'h0, 32'h7FFF_FFFF, 8'h0F, 8'hF0);
      write_max_payload(12'd6);
      send_fields(8'hC0, 24'hFF_FFFF, 1'b0, 32'h0, 32'h0, 8'h0F, 8'hF0);
      // length drops so that this byte ends the unit
      send_fields(8'h3F, 24'd6, 1'b1, 32'h0, 32'h0, 8'h0F, 8'hF0);
   endtask

   task automatic test_random_traffic();
      logic [MaxPayloadBits-1:0] setting;
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: setting = 12'd4;
            1: setting = MaxPayloadBits'($urandom_range(16, 5));
            2: setting = MaxPayloadBits'($urandom_range(3, 0));
            3: setting = MaxPayloadBits'($urandom_range(16, 5));
            default: setting = 12'd4095;
         endcase
         write_max_payload(setting);
         send_random_bytes(34);
      end
   endtask

   task automatic test_steady_stream();
      write_max_payload(MaxPayloadBits'($urandom_range(12, 5)));
      steady = 1'b1;
      send_random_bytes(40);
      wait_until_idle();
      steady = 1'b0;
   endtask

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      steady             = 1'b0;
      error_count        = 0;
      results_seen       = 0;
      cycle_count        = 0;
      req_if.valid       = 1'b0;
      req_if.data_byte   = '0;
      req_if.unit_length = '0;
      req_if.marker_in   = 1'b0;
      req_if.stamp_in    = '0;
      req_if.now_ticks   = '0;
      req_if.frame_kind  = '0;
      req_if.channel     = '0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.max_payload = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_single_packet();
      test_fu_split();
      test_limit_floor();
      test_limit_change_in_unit();
      test_random_traffic();
      test_steady_stream();

      wait_until_idle();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* hevc_rtp_fragmenter_core.f */
design/hrf_pkg.sv
design/hrf_if.sv
design/hrf_front.sv
design/hrf_queue.sv
design/hrf_back.sv
design/hevc_rtp_fragmenter_core.sv
tb/hevc_rtp_fragmenter_core_tb.sv
